// ===== hdl/ubx_frame_parser_unit_defines.svh =====
// Assertion helpers used by the parser step logic (ubxfp_step).
`ifndef UBX_FRAME_PARSER_UNIT_DEFINES_SVH
`define UBX_FRAME_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst is high.
`define UBXFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst is high.
`define UBXFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ubxfp_pkg.sv =====
package ubxfp_pkg;

  localparam logic [7:0]  SYNC_FIRST_RST  = 8'hB5;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'h62;
  localparam logic [15:0] MAX_LEN_RST     = 16'd512;

  localparam int unsigned ADDR_W = 4;

  localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] REG_MAX_LEN     = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN1    = 4'd4,
    PH_LEN2    = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CK1     = 4'd7,
    PH_CK2     = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_HEADER  = 3'd1,
    EV_PAYLOAD = 3'd2,
    EV_GOOD    = 3'd3,
    EV_CKBAD   = 3'd4,
    EV_SYNCERR = 3'd5,
    EV_TOOLONG = 3'd6
  } event_t;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] max_len;
  } cfg_t;

  typedef struct packed {
    event_t      ev;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] msg_length;
    logic [7:0]  payload_byte;
    logic [15:0] payload_position;
    logic [31:0] good_frames;
    logic [31:0] framing_errors;
    logic [31:0] bad_checksums;
  } res_t;

endpackage

// ===== hdl/ubxfp_cfg.sv =====
module ubxfp_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ubxfp_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output ubxfp_pkg::cfg_t                cfg
);
  import ubxfp_pkg::*;

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first  <= SYNC_FIRST_RST;
      cfg.sync_second <= SYNC_SECOND_RST;
      cfg.max_len     <= MAX_LEN_RST;
    end else if (wr) begin
      case (idx)
        REG_SYNC_FIRST:  cfg.sync_first  <= pwdata[7:0];
        REG_SYNC_SECOND: cfg.sync_second <= pwdata[7:0];
        REG_MAX_LEN:     cfg.max_len     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SYNC_FIRST:  prdata = {24'd0, cfg.sync_first};
      REG_SYNC_SECOND: prdata = {24'd0, cfg.sync_second};
      REG_MAX_LEN:     prdata = {16'd0, cfg.max_len};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

// ===== hdl/ubxfp_step.sv =====
`include "ubx_frame_parser_unit_defines.svh"

module ubxfp_step (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      rx_byte,
  input  ubxfp_pkg::cfg_t cfg,
  output ubxfp_pkg::res_t res
);
  import ubxfp_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  sum_a, sum_a_next, sum_b, sum_b_next;
  logic [7:0]  class_reg, class_reg_next, id_reg, id_reg_next;
  logic [15:0] length_reg, length_reg_next;
  logic [15:0] byte_index, byte_index_next;
  logic [7:0]  received_sum_a, received_sum_a_next;
  logic [31:0] good_count, good_count_next;
  logic [31:0] framing_error_count, framing_error_count_next;
  logic [31:0] checksum_error_count, checksum_error_count_next;

  logic [7:0]  add_a, add_b;
  logic [15:0] len_full, idx_inc;
  event_t      ev;
  logic [7:0]  pbyte;
  logic [15:0] ppos;

  assign add_a    = sum_a + rx_byte;
  assign add_b    = sum_b + add_a;
  assign len_full = {rx_byte, length_reg[7:0]};
  assign idx_inc  = (byte_index != 16'hFFFF) ? byte_index + 16'd1 : byte_index;

  always_comb begin
    phase_next                = phase;
    sum_a_next                = sum_a;
    sum_b_next                = sum_b;
    class_reg_next            = class_reg;
    id_reg_next               = id_reg;
    length_reg_next           = length_reg;
    byte_index_next           = byte_index;
    received_sum_a_next       = received_sum_a;
    good_count_next           = good_count;
    framing_error_count_next  = framing_error_count;
    checksum_error_count_next = checksum_error_count;
    ev    = EV_NONE;
    pbyte = 8'd0;
    ppos  = 16'd0;
    case (phase)
      PH_IDLE: begin
        if (rx_byte == cfg.sync_first) begin
          phase_next = PH_SYNC2;
          sum_a_next = 8'd0;
          sum_b_next = 8'd0;
        end
      end
      PH_SYNC2: begin
        if (rx_byte == cfg.sync_second) begin
          phase_next = PH_CLASS;
        end else begin
          // no resync on the mismatching word
          phase_next               = PH_IDLE;
          framing_error_count_next = framing_error_count + 32'd1;
          ev                       = EV_SYNCERR;
        end
      end
      PH_CLASS: begin
        class_reg_next = rx_byte;
        sum_a_next     = add_a;
        sum_b_next     = add_b;
        phase_next     = PH_ID;
      end
      PH_ID: begin
        id_reg_next = rx_byte;
        sum_a_next  = add_a;
        sum_b_next  = add_b;
        phase_next  = PH_LEN1;
      end
      PH_LEN1: begin
        length_reg_next = {8'd0, rx_byte};
        sum_a_next      = add_a;
        sum_b_next      = add_b;
        phase_next      = PH_LEN2;
      end
      PH_LEN2: begin
        length_reg_next = len_full;
        sum_a_next      = add_a;
        sum_b_next      = add_b;
        if (len_full > cfg.max_len) begin
          phase_next               = PH_IDLE;
          framing_error_count_next = framing_error_count + 32'd1;
          ev                       = EV_TOOLONG;
        end else begin
          byte_index_next = 16'd0;
          phase_next      = (len_full == 16'd0) ? PH_CK1 : PH_PAYLOAD;
          ev              = EV_HEADER;
        end
      end
      PH_PAYLOAD: begin
        ev              = EV_PAYLOAD;
        pbyte           = rx_byte;
        ppos            = byte_index;
        sum_a_next      = add_a;
        sum_b_next      = add_b;
        byte_index_next = idx_inc;
        if (idx_inc >= length_reg) phase_next = PH_CK1;
      end
      PH_CK1: begin
        received_sum_a_next = rx_byte;
        phase_next          = PH_CK2;
      end
      PH_CK2: begin
        phase_next = PH_IDLE;
        if (received_sum_a == sum_a && rx_byte == sum_b) begin
          good_count_next = good_count + 32'd1;
          ev              = EV_GOOD;
        end else begin
          checksum_error_count_next = checksum_error_count + 32'd1;
          ev                        = EV_CKBAD;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_comb begin
    res.ev               = ev;
    res.msg_class        = class_reg_next;
    res.msg_id           = id_reg_next;
    res.msg_length       = length_reg_next;
    res.payload_byte     = pbyte;
    res.payload_position = ppos;
    res.good_frames      = good_count_next;
    res.framing_errors   = framing_error_count_next;
    res.bad_checksums    = checksum_error_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase                <= PH_IDLE;
      sum_a                <= 8'd0;
      sum_b                <= 8'd0;
      class_reg            <= 8'd0;
      id_reg               <= 8'd0;
      length_reg           <= 16'd0;
      byte_index           <= 16'd0;
      received_sum_a       <= 8'd0;
      good_count           <= 32'd0;
      framing_error_count  <= 32'd0;
      checksum_error_count <= 32'd0;
    end else if (accept) begin
      phase                <= phase_next;
      sum_a                <= sum_a_next;
      sum_b                <= sum_b_next;
      class_reg            <= class_reg_next;
      id_reg               <= id_reg_next;
      length_reg           <= length_reg_next;
      byte_index           <= byte_index_next;
      received_sum_a       <= received_sum_a_next;
      good_count           <= good_count_next;
      framing_error_count  <= framing_error_count_next;
      checksum_error_count <= checksum_error_count_next;
    end
  end

  `UBXFP_ASSERT_NEXT(a_good_count_step, accept && res.ev == EV_GOOD,
    good_count == $past(good_count) + 32'd1, "good frame count did not advance")
  `UBXFP_ASSERT_NEXT(a_frame_err_step, accept && (res.ev == EV_SYNCERR || res.ev == EV_TOOLONG),
    framing_error_count == $past(framing_error_count) + 32'd1,
    "framing error count did not advance")
  `UBXFP_ASSERT_NOW(a_pos_in_range, accept && res.ev == EV_PAYLOAD,
    byte_index < length_reg, "payload position beyond header length")
  `UBXFP_ASSERT_NEXT(a_ck2_to_idle, accept && phase == PH_CK2,
    phase == PH_IDLE, "parser did not return to idle after checksum")

endmodule

// ===== hdl/ubxfp_out_reg.sv =====
module ubxfp_out_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  ubxfp_pkg::res_t d,
  input  logic            out_stall,
  output logic            out_valid,
  output ubxfp_pkg::res_t q
);
  import ubxfp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // payload holds unless a new word is loaded
  always_ff @(posedge clk) begin
    if (load) q <= d;
  end

endmodule

// ===== hdl/ubx_frame_parser_unit.sv =====
// Binary frame parser: sync pair, class, id, 16-bit little-endian length,
// payload, then a two-byte Fletcher-8 checksum over class through payload.
// Input channel: in_valid / in_stall carrying one received word (rx_byte).
// Output channel: out_valid / out_stall; every accepted word yields exactly
//   one result word (event code, header fields, payload byte and position,
//   and the good-frame, framing-error and checksum-error counters).
// Latency: the result is presented on the cycle after the input is accepted.
// Throughput: one word per cycle unless stalled; the only loop is the parser
//   state update, one byte per cycle through a single add-and-compare stage.
// Stall: in_stall rises only while the result register is full and the
//   receiver stalls it; a result held there does not change.
// Reset (rst, synchronous): parser to idle, sums, header fields and
//   counters to zero, result register empty, sync bytes 0xB5 / 0x62 and
//   maximum payload length 512.
// Configuration: APB writes at 0x0 (first sync), 0x4 (second sync) and
//   0x8 (maximum payload length); write only while the parser is quiet.
module ubx_frame_parser_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   rx_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   event_res,
  output logic [7:0]                   msg_class,
  output logic [7:0]                   msg_id,
  output logic [15:0]                  msg_length,
  output logic [7:0]                   payload_byte,
  output logic [15:0]                  payload_position,
  output logic [31:0]                  good_frames,
  output logic [31:0]                  framing_errors,
  output logic [31:0]                  bad_checksums,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ubxfp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import ubxfp_pkg::*;

  cfg_t cfg;
  res_t step_res;
  res_t out_q;
  logic accept;

  // Stall the sender only while a finished word waits and is itself stalled.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  ubxfp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Parser state and the per-byte next-state / result logic.
  ubxfp_step u_step (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .cfg     (cfg),
    .res     (step_res)
  );

  // Result register: capture on accept, hold while stalled.
  ubxfp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .d         (step_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .q         (out_q)
  );

  assign event_res        = out_q.ev;
  assign msg_class        = out_q.msg_class;
  assign msg_id           = out_q.msg_id;
  assign msg_length       = out_q.msg_length;
  assign payload_byte     = out_q.payload_byte;
  assign payload_position = out_q.payload_position;
  assign good_frames      = out_q.good_frames;
  assign framing_errors   = out_q.framing_errors;
  assign bad_checksums    = out_q.bad_checksums;

endmodule
